@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property checked every cycle out of reset.
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checked in the cycle after reset is seen.
`define CHK_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mmp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmp_pkg
// Register map, reset values and shared constants for the propensity block.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KM   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KCAT = 8'd1;

  localparam logic [CFG_DATA_W-1:0] KM_RESET   = 32'h0001_0000;
  localparam logic [CFG_DATA_W-1:0] KCAT_RESET = 32'h0001_0000;

  // Fraction bits of the Km and kcat registers.
  localparam int REG_FRAC = 16;
  // Chunk width for partial products.
  localparam int CHUNK_W = 32;

endpackage

@@ rtl/core/mmp_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// mmp_sqrt_pipe
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module mmp_sqrt_pipe #(
  parameter int RW   = 42,
  parameter int SB_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_disc,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RM_W = RW + 3;

  logic              vld_w  [0:RW];
  logic [2*RW-1:0]   dsh_w  [0:RW];
  logic [RM_W-1:0]   rem_w  [0:RW];
  logic [RW-1:0]     root_w [0:RW];
  logic [SB_W-1:0]   sb_w   [0:RW];

  logic              vld_r  [0:RW-1];
  logic [2*RW-1:0]   dsh_r  [0:RW-1];
  logic [RM_W-1:0]   rem_r  [0:RW-1];
  logic [RW-1:0]     root_r [0:RW-1];
  logic [SB_W-1:0]   sb_r   [0:RW-1];

  assign vld_w[0]  = in_valid;
  assign dsh_w[0]  = in_disc;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign sb_w[0]   = in_sb;

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RM_W-1:0] cand;
    logic [RM_W-1:0] trial;
    logic            take;

    // bring down the next two bits, try root*4+1
    assign cand  = {rem_w[k][RM_W-3:0], dsh_w[k][2*RW-1 -: 2]};
    assign trial = RM_W'({root_w[k], 2'b01});
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? (cand - trial) : cand;
        root_r[k] <= {root_w[k][RW-2:0], take};
        dsh_r[k]  <= dsh_w[k] << 2;
        sb_r[k]   <= sb_w[k];
      end
    end

    assign vld_w[k+1]  = vld_r[k];
    assign dsh_w[k+1]  = dsh_r[k];
    assign rem_w[k+1]  = rem_r[k];
    assign root_w[k+1] = root_r[k];
    assign sb_w[k+1]   = sb_r[k];
  end

  assign out_valid = vld_w[RW];
  assign out_root  = root_w[RW];
  assign out_sb    = sb_w[RW];

endmodule

@@ rtl/core/mmp_div_pipe.sv @@
// ----------------------------------------------------------------------------
// mmp_div_pipe
// Restoring divider, one quotient bit per register stage. The caller
// guarantees num >> Q_W is below den for results it keeps.
// ----------------------------------------------------------------------------
module mmp_div_pipe #(
  parameter int N_W  = 98,
  parameter int D_W  = 43,
  parameter int Q_W  = 56,
  parameter int SB_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    in_num,
  input  logic [D_W-1:0]    in_den,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SB_W-1:0]   out_sb
);

  localparam int HI_W = N_W - Q_W;

  logic [HI_W+D_W-1:0] hi_ext;

  logic              vld_w [0:Q_W];
  logic [D_W-1:0]    rem_w [0:Q_W];
  logic [Q_W-1:0]    lo_w  [0:Q_W];
  logic [Q_W-1:0]    quo_w [0:Q_W];
  logic [D_W-1:0]    den_w [0:Q_W];
  logic [SB_W-1:0]   sb_w  [0:Q_W];

  logic              vld_r [0:Q_W-1];
  logic [D_W-1:0]    rem_r [0:Q_W-1];
  logic [Q_W-1:0]    lo_r  [0:Q_W-1];
  logic [Q_W-1:0]    quo_r [0:Q_W-1];
  logic [D_W-1:0]    den_r [0:Q_W-1];
  logic [SB_W-1:0]   sb_r  [0:Q_W-1];

  assign hi_ext   = {{D_W{1'b0}}, in_num[N_W-1:Q_W]};
  assign vld_w[0] = in_valid;
  assign rem_w[0] = hi_ext[D_W-1:0];
  assign lo_w[0]  = in_num[Q_W-1:0];
  assign quo_w[0] = '0;
  assign den_w[0] = in_den;
  assign sb_w[0]  = in_sb;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [D_W:0] cand;
    logic [D_W:0] diff;
    logic         take;

    assign cand = {rem_w[k], lo_w[k][Q_W-1]};
    assign diff = cand - {1'b0, den_w[k]};
    assign take = (cand >= {1'b0, den_w[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[D_W-1:0] : cand[D_W-1:0];
        lo_r[k]  <= lo_w[k] << 1;
        quo_r[k] <= {quo_w[k][Q_W-2:0], take};
        den_r[k] <= den_w[k];
        sb_r[k]  <= sb_w[k];
      end
    end

    assign vld_w[k+1] = vld_r[k];
    assign rem_w[k+1] = rem_r[k];
    assign lo_w[k+1]  = lo_r[k];
    assign quo_w[k+1] = quo_r[k];
    assign den_w[k+1] = den_r[k];
    assign sb_w[k+1]  = sb_r[k];
  end

  assign out_valid = vld_w[Q_W];
  assign out_quo   = quo_w[Q_W];
  assign out_sb    = sb_w[Q_W];

endmodule

@@ rtl/core/michaelis_menten_propensity.sv @@
// ----------------------------------------------------------------------------
// michaelis_menten_propensity
// Michaelis-Menten propensity with quadratic free-substrate correction.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries a substrate count and an enzyme count.
//   out_* : one beat per input beat, in order: propensity (Q.FRAC_BITS,
//           saturating), free substrate and the saturation flag.
//   cfg_* : register writes, index 0 = Km, index 1 = kcat (both Q16.16).
//           Always ready; write only while the pipe is empty.
// Throughput: one beat per cycle, sustained while the output is not stalled.
// Pipeline: stages 1 to 3, the root pipe (one pipe stage per root bit, RW the
//   root width), sFree, m1 to m4, prep, the divider (one divider stage per
//   quotient bit, PW the propensity width) and the output register.
// Stall: the whole pipe holds while the output register is full and
//   out_ready is low; in_ready follows. No beat is lost or repeated.
// Reset: synchronous, active low. Clears every stage valid and restores
//   Km and kcat to 1.0.
// A zero denominator (Km + sFree) gives propensity 0, flag clear.
// ----------------------------------------------------------------------------
module michaelis_menten_propensity #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [COUNT_BITS-1:0]                 in_substrate_count,
  input  logic [COUNT_BITS-1:0]                 in_enzyme_count,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [((COUNT_BITS+16+FRAC_BITS > 64) ? 64 :
                 COUNT_BITS+16+FRAC_BITS)-1:0]  out_propensity,
  output logic [COUNT_BITS+FRAC_BITS-1:0]       out_free_substrate,
  output logic                                  out_saturated,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  // ---- widths -------------------------------------------------------------
  localparam int CW     = COUNT_BITS;
  localparam int FB     = FRAC_BITS;
  localparam int UP_SH  = (FB >= mmp_pkg::REG_FRAC) ? FB - mmp_pkg::REG_FRAC : 0;
  localparam int DN_SH  = (FB >= mmp_pkg::REG_FRAC) ? 0 : mmp_pkg::REG_FRAC - FB;
  localparam int KQ_W   = mmp_pkg::CFG_DATA_W + UP_SH;        // Km at FB fraction
  localparam int SQ_W   = CW + FB;                            // S at FB fraction
  localparam int MAG_W  = ((KQ_W > SQ_W) ? KQ_W : SQ_W) + 1;  // |d|
  localparam int ML_W   = (MAG_W + 1) / 2;
  localparam int MH_W   = MAG_W - ML_W;
  localparam int MSQ_W  = 2 * MAG_W;
  localparam int KS_W   = KQ_W + CW;                          // Km*S
  localparam int KSS_W  = KS_W + FB + 2;
  localparam int DISC_W = ((MSQ_W > KSS_W) ? MSQ_W : KSS_W) + 1;
  localparam int RW     = (DISC_W + 1) / 2;                   // root width
  localparam int SF_W   = RW;                                 // sFree
  localparam int DEN_W  = ((KQ_W > SF_W) ? KQ_W : SF_W) + 1;
  localparam int D_W    = DEN_W + DN_SH;
  localparam int FH_W   = (SF_W + 1) / 2;
  localparam int KC_W   = mmp_pkg::CFG_DATA_W + SF_W;         // kcat*sFree
  localparam int NCH    = (KC_W + mmp_pkg::CHUNK_W - 1) / mmp_pkg::CHUNK_W;
  localparam int KCP_W  = NCH * mmp_pkg::CHUNK_W;
  localparam int PP_W   = mmp_pkg::CHUNK_W + CW;
  localparam int NUM_W  = KC_W + CW;
  localparam int N_W    = NUM_W + UP_SH;
  localparam int PW     = (CW + 16 + FB > 64) ? 64 : CW + 16 + FB;
  localparam int HI_W   = N_W - PW;
  localparam int CMP_W  = ((HI_W > D_W) ? HI_W : D_W);
  localparam int OF_W   = CW + FB;
  localparam int SQ_SB  = CW + MAG_W + 1;
  localparam int DV_SB  = OF_W + 2;

  // ---- configuration registers --------------------------------------------
  logic [mmp_pkg::CFG_DATA_W-1:0] km_r, kcat_r;
  logic [KQ_W-1:0]                kmq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      km_r   <= mmp_pkg::KM_RESET;
      kcat_r <= mmp_pkg::KCAT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmp_pkg::CFG_KM:   km_r   <= cfg_data;
        mmp_pkg::CFG_KCAT: kcat_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Km rescaled to FB fraction bits (truncating when FB < 16)
  assign kmq = (KQ_W'(km_r) << UP_SH) >> DN_SH;

  // ---- pipe enable: stall everything while the output beat waits ---------
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---- stage 1: d = S - Km - E as sign and magnitude ----------------------
  logic [MAG_W-1:0] sqx, sub, mag;
  logic             dpos;

  assign sqx  = MAG_W'(in_substrate_count) << FB;
  assign sub  = MAG_W'(kmq) + (MAG_W'(in_enzyme_count) << FB);
  assign dpos = (sqx >= sub);
  assign mag  = dpos ? (sqx - sub) : (sub - sqx);

  logic             s1_vld_r;
  logic [CW-1:0]    s1_s_r, s1_e_r;
  logic [MAG_W-1:0] s1_mag_r;
  logic             s1_dpos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r    <= in_substrate_count;
      s1_e_r    <= in_enzyme_count;
      s1_mag_r  <= mag;
      s1_dpos_r <= dpos;
    end
  end

  // ---- stage 2: partial products of d*d and Km*S --------------------------
  logic                s2_vld_r;
  logic [2*MH_W-1:0]   s2_hh_r;
  logic [MH_W+ML_W-1:0] s2_hl_r;
  logic [2*ML_W-1:0]   s2_ll_r;
  logic [KS_W-1:0]     s2_ks_r;
  logic [CW-1:0]       s2_e_r;
  logic [MAG_W-1:0]    s2_mag_r;
  logic                s2_dpos_r;
  logic [MH_W-1:0]     mag_hi;
  logic [ML_W-1:0]     mag_lo;

  assign mag_hi = s1_mag_r[MAG_W-1:ML_W];
  assign mag_lo = s1_mag_r[ML_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hh_r   <= mag_hi * mag_hi;
      s2_hl_r   <= mag_hi * mag_lo;
      s2_ll_r   <= mag_lo * mag_lo;
      s2_ks_r   <= KS_W'(kmq) * KS_W'(s1_s_r);
      s2_e_r    <= s1_e_r;
      s2_mag_r  <= s1_mag_r;
      s2_dpos_r <= s1_dpos_r;
    end
  end

  // ---- stage 3: discriminant d*d + 4*Km*S ---------------------------------
  logic              s3_vld_r;
  logic [2*RW-1:0]   s3_disc_r;
  logic [2*RW-1:0]   disc_nxt;
  logic [SQ_SB-1:0]  s3_sb_r;

  assign disc_nxt = ((2*RW)'(s2_hh_r) << (2*ML_W))
                  + ((2*RW)'(s2_hl_r) << (ML_W + 1))
                  + (2*RW)'(s2_ll_r)
                  + ((2*RW)'(s2_ks_r) << (FB + 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_disc_r <= disc_nxt;
      s3_sb_r   <= {s2_e_r, s2_mag_r, s2_dpos_r};
    end
  end

  // ---- square root pipe ---------------------------------------------------
  logic             rt_vld;
  logic [RW-1:0]    rt_root;
  logic [SQ_SB-1:0] rt_sb;

  mmp_sqrt_pipe #(
    .RW   (RW),
    .SB_W (SQ_SB)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_disc   (s3_disc_r),
    .in_sb     (s3_sb_r),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_sb    (rt_sb)
  );

  // ---- sFree = (d + root) / 2, den = Km + sFree ---------------------------
  logic [CW-1:0]    rt_e;
  logic [MAG_W-1:0] rt_mag;
  logic             rt_dpos;
  logic [RW:0]      sf_sum;

  assign rt_e    = rt_sb[SQ_SB-1 -: CW];
  assign rt_mag  = rt_sb[MAG_W:1];
  assign rt_dpos = rt_sb[0];
  assign sf_sum  = rt_dpos ? ((RW+1)'(rt_mag) + (RW+1)'(rt_root))
                           : ((RW+1)'(rt_root) - (RW+1)'(rt_mag));

  logic             sf_vld_r;
  logic [SF_W-1:0]  sf_free_r;
  logic [DEN_W-1:0] sf_den_r;
  logic [CW-1:0]    sf_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_vld_r <= 1'b0;
    end else if (en) begin
      sf_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_free_r <= sf_sum[RW:1];
      sf_den_r  <= DEN_W'(kmq) + DEN_W'(sf_sum[RW:1]);
      sf_e_r    <= rt_e;
    end
  end

  // ---- m1: kcat * sFree, two halves ---------------------------------------
  logic                                   m1_vld_r;
  logic [mmp_pkg::CFG_DATA_W+FH_W-1:0]    m1_pl_r;
  logic [mmp_pkg::CFG_DATA_W+SF_W-FH_W-1:0] m1_ph_r;
  logic [SF_W-1:0]                        m1_free_r;
  logic [DEN_W-1:0]                       m1_den_r;
  logic [CW-1:0]                          m1_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= sf_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_pl_r   <= (mmp_pkg::CFG_DATA_W+FH_W)'(kcat_r) *
                   (mmp_pkg::CFG_DATA_W+FH_W)'(sf_free_r[FH_W-1:0]);
      m1_ph_r   <= (mmp_pkg::CFG_DATA_W+SF_W-FH_W)'(kcat_r) *
                   (mmp_pkg::CFG_DATA_W+SF_W-FH_W)'(sf_free_r[SF_W-1:FH_W]);
      m1_free_r <= sf_free_r;
      m1_den_r  <= sf_den_r;
      m1_e_r    <= sf_e_r;
    end
  end

  // ---- m2: combine halves -------------------------------------------------
  logic             m2_vld_r;
  logic [KCP_W-1:0] m2_kc_r;
  logic [SF_W-1:0]  m2_free_r;
  logic [DEN_W-1:0] m2_den_r;
  logic [CW-1:0]    m2_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_kc_r   <= (KCP_W'(m1_ph_r) << FH_W) + KCP_W'(m1_pl_r);
      m2_free_r <= m1_free_r;
      m2_den_r  <= m1_den_r;
      m2_e_r    <= m1_e_r;
    end
  end

  // ---- m3: (kcat*sFree) * E, one chunk per multiplier ---------------------
  logic             m3_vld_r;
  logic [PP_W-1:0]  m3_pp_r [0:NCH-1];
  logic [SF_W-1:0]  m3_free_r;
  logic [DEN_W-1:0] m3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        m3_pp_r[c] <= PP_W'(m2_kc_r[c*mmp_pkg::CHUNK_W +: mmp_pkg::CHUNK_W]) * PP_W'(m2_e_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_free_r <= m2_free_r;
      m3_den_r  <= m2_den_r;
    end
  end

  // ---- m4: sum of chunk products ------------------------------------------
  logic [NUM_W-1:0] num_nxt;

  always_comb begin
    num_nxt = '0;
    for (int c = 0; c < NCH; c++) begin
      num_nxt = num_nxt + (NUM_W'(m3_pp_r[c]) << (c * mmp_pkg::CHUNK_W));
    end
  end

  logic             m4_vld_r;
  logic [NUM_W-1:0] m4_num_r;
  logic [SF_W-1:0]  m4_free_r;
  logic [DEN_W-1:0] m4_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_vld_r <= 1'b0;
    end else if (en) begin
      m4_vld_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m4_num_r  <= num_nxt;
      m4_free_r <= m3_free_r;
      m4_den_r  <= m3_den_r;
    end
  end

  // ---- prep: scale operands, detect overflow and zero denominator ---------
  logic [N_W-1:0]   pn;
  logic [D_W-1:0]   pd;
  logic [CMP_W-1:0] pn_hi, pd_x;

  assign pn    = N_W'(m4_num_r) << UP_SH;
  assign pd    = D_W'(m4_den_r) << DN_SH;
  assign pn_hi = CMP_W'(pn[N_W-1:PW]);
  assign pd_x  = CMP_W'(pd);

  logic             pr_vld_r;
  logic [N_W-1:0]   pr_num_r;
  logic [D_W-1:0]   pr_den_r;
  logic [DV_SB-1:0] pr_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else if (en) begin
      pr_vld_r <= m4_vld_r;
    end
  end

  // sideband: {free substrate, overflow, zero denominator}
  always_ff @(posedge clk) begin
    if (en) begin
      pr_num_r <= pn;
      pr_den_r <= pd;
      pr_sb_r  <= {m4_free_r[OF_W-1:0], (pn_hi >= pd_x), (m4_den_r == '0)};
    end
  end

  // ---- divider pipe -------------------------------------------------------
  logic             dv_vld;
  logic [PW-1:0]    dv_quo;
  logic [DV_SB-1:0] dv_sb;

  mmp_div_pipe #(
    .N_W  (N_W),
    .D_W  (D_W),
    .Q_W  (PW),
    .SB_W (DV_SB)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pr_vld_r),
    .in_num    (pr_num_r),
    .in_den    (pr_den_r),
    .in_sb     (pr_sb_r),
    .out_valid (dv_vld),
    .out_quo   (dv_quo),
    .out_sb    (dv_sb)
  );

  // ---- output register ----------------------------------------------------
  logic [PW-1:0]   prop_r;
  logic [OF_W-1:0] free_r;
  logic            sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      free_r <= dv_sb[DV_SB-1:2];
      sat_r  <= dv_sb[1] && !dv_sb[0];
      if (dv_sb[0]) begin
        prop_r <= '0;
      end else if (dv_sb[1]) begin
        prop_r <= '1;
      end else begin
        prop_r <= dv_quo;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_propensity     = prop_r;
  assign out_free_substrate = free_r;
  assign out_saturated      = sat_r;

endmodule

@@ rtl/core/mmp_checker.sv @@
// ----------------------------------------------------------------------------
// mmp_checker
// Port-level checks for the propensity block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmp_checker #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [((COUNT_BITS+16+FRAC_BITS > 64) ? 64 :
                COUNT_BITS+16+FRAC_BITS)-1:0]  out_propensity,
  input logic [COUNT_BITS+FRAC_BITS-1:0]       out_free_substrate,
  input logic                                  out_saturated
);

  `CHK_RESET(a_reset_empty, !out_valid, "output beat present after reset")
  `CHK_IMPLY(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_propensity), "output beat dropped or changed under stall")
  `CHK_IMPLY(a_sat_is_max, out_valid && out_saturated, (&out_propensity) && (out_free_substrate != '0), "saturated beat without full-scale propensity")

endmodule

bind michaelis_menten_propensity mmp_checker #(
  .COUNT_BITS (COUNT_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_mmp_checker (.*);
